/* hdl/plim_pkg.sv */
// Shared types, constants and sequence tables for the parallel lane I2C master.
package plim_pkg;

  // Number of lanes wired to devices; lanes at or above this count stay released.
  localparam int unsigned LANE_COUNT = 4;
  localparam int unsigned SLOTS      = 4;

  // Lanes that may be driven and sampled.
  localparam logic [SLOTS-1:0] LANE_OK =
    (LANE_COUNT >= SLOTS) ? {SLOTS{1'b1}} : SLOTS'((1 << LANE_COUNT) - 1);

  // Register reset values.
  localparam logic [6:0] ADDR_RESET    = 7'd72;
  localparam logic [7:0] VALREG_RESET  = 8'd80;

  // Configuration register indexes.
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_VALUE_REGISTER = 1'b1;

  // Command codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_WRITE_REG  = 2'd1,
    OP_READ_REG   = 2'd2,
    OP_READ_VALUE = 2'd3
  } op_t;

  // Bus segments, one-hot.
  typedef enum logic [10:0] {
    SEG_END     = 11'b000_0000_0001,
    SEG_START   = 11'b000_0000_0010,
    SEG_TX_AW   = 11'b000_0000_0100,
    SEG_TX_REG  = 11'b000_0000_1000,
    SEG_TX_DATA = 11'b000_0001_0000,
    SEG_TX_AR   = 11'b000_0010_0000,
    SEG_RX      = 11'b000_0100_0000,
    SEG_MACK    = 11'b000_1000_0000,
    SEG_MNACK   = 11'b001_0000_0000,
    SEG_RESTART = 11'b010_0000_0000,
    SEG_STOP    = 11'b100_0000_0000
  } seg_t;

  localparam int unsigned SEQ_SLOTS = 10;

  localparam seg_t WRITE_SEQ [SEQ_SLOTS] = '{
    SEG_START, SEG_TX_AW, SEG_TX_REG, SEG_TX_DATA, SEG_STOP,
    SEG_END, SEG_END, SEG_END, SEG_END, SEG_END
  };
  localparam seg_t READ_SEQ [SEQ_SLOTS] = '{
    SEG_START, SEG_TX_AW, SEG_TX_REG, SEG_RESTART, SEG_TX_AR,
    SEG_RX, SEG_MNACK, SEG_STOP, SEG_END, SEG_END
  };
  localparam seg_t VALUE_SEQ [SEQ_SLOTS] = '{
    SEG_START, SEG_TX_AW, SEG_TX_REG, SEG_RESTART, SEG_TX_AR,
    SEG_RX, SEG_MACK, SEG_RX, SEG_MNACK, SEG_STOP
  };

  // Segment at a given position of a command's sequence.
  function automatic seg_t seg_at(input op_t cmd, input logic [3:0] idx);
    seg_t seg;
    seg = SEG_END;
    if (idx < 4'(SEQ_SLOTS)) begin
      case (cmd)
        OP_WRITE_REG:  seg = WRITE_SEQ[idx];
        OP_READ_REG:   seg = READ_SEQ[idx];
        OP_READ_VALUE: seg = VALUE_SEQ[idx];
        default:       seg = SEG_END;
      endcase
    end
    return seg;
  endfunction

  // Number of half-phases in a segment.
  function automatic logic [4:0] seg_len(input seg_t seg);
    logic [4:0] len;
    case (seg)
      SEG_START, SEG_STOP:                             len = 5'd3;
      SEG_TX_AW, SEG_TX_REG, SEG_TX_DATA, SEG_TX_AR:   len = 5'd18;
      SEG_RX:                                          len = 5'd16;
      SEG_MACK, SEG_MNACK:                             len = 5'd2;
      SEG_RESTART:                                     len = 5'd4;
      default:                                         len = 5'd1;
    endcase
    return len;
  endfunction

endpackage

/* hdl/parallel_lane_i2c_master.sv */
// Top level of the parallel lane I2C master: sequencer, lane capture and output register.
//
// Usage. Each transfer on the slave stream is one bus half-phase. While the
// master is idle, an operation other than tick starts a command: register
// write, register read or two-byte value read, on the lanes set in lane_mask.
// From then on every transfer, whatever its operation, yields one SCL level
// and one SDA drive pattern per lane, and the sda_sample bits of the transfer
// are captured on the high halves of receive bits. The master stream carries
// one result per input transfer; tlast marks the half-phase on which the stop
// condition completes, and only that result carries the read slots.
// A result is registered at the edge that takes the input transfer. Throughput
// is one transfer per cycle; the input is taken whenever the output register
// is empty or is being emptied in the same cycle, so a stall on the master
// side holds the result and stops the slave side without losing anything.
// Reset empties the output register, returns the sequencer to idle and
// restores the address 72 and value register 80.
// The APB port writes device_address at 0x0 and value_register at 0x4.
module parallel_lane_i2c_master (
  input  logic        clk,
  input  logic        rst,
  // Slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // lane_mask[3:0], reg_index[11:4], write_value[19:12], sda_sample[23:20]
  input  logic [23:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  // Master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_level[0], sda_drive[4:1], busy_res[5], slot0_value[20:6],
  // slot1_value[35:21], slot2_value[50:36], slot3_value[65:51], zero[71:66]
  output logic [71:0] m_tdata,
  // done_res
  output logic        m_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import plim_pkg::*;

  // Configuration registers
  logic [6:0] device_address;
  logic [7:0] value_register;

  // Sequencer state
  op_t        active_command;
  logic [3:0] seg_idx;
  logic [4:0] phase;
  logic [3:0] latched_mask;
  logic [7:0] latched_register;
  logic [7:0] latched_write_byte;
  logic [15:0] lane_capture [SLOTS];

  // Input fields
  op_t        in_op;
  logic [3:0] in_mask;
  logic [7:0] in_reg;
  logic [7:0] in_wbyte;
  logic [3:0] in_sda;

  // Effective values for this half-phase
  logic        accept;
  logic        start;
  op_t         cmd_e;
  logic [3:0]  mask_e;
  logic [7:0]  reg_e;
  logic [7:0]  wbyte_e;
  logic [3:0]  idx_e;
  logic [4:0]  phase_e;
  logic [15:0] cap_e [SLOTS];
  seg_t        seg;
  logic [7:0]  tx_byte;
  logic        scl;
  logic        sda;
  logic        sample;
  logic        last;
  logic        run;
  logic [3:0]  pins;
  logic [3:0]  drive;
  logic [15:0] cap_next [SLOTS];
  logic [15:0] swapped;
  logic [14:0] slot [SLOTS];

  assign in_op    = op_t'(s_tuser);
  assign in_mask  = s_tdata[3:0];
  assign in_reg   = s_tdata[11:4];
  assign in_wbyte = s_tdata[19:12];
  assign in_sda   = s_tdata[23:20];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration port: always ready, reads return the register value.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VALUE_REGISTER) ? {24'd0, value_register}
                                                   : {25'd0, device_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
      value_register <= VALREG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_DEVICE_ADDRESS) begin
        device_address <= pwdata[6:0];
      end else begin
        value_register <= pwdata[7:0];
      end
    end
  end

  // A new command latches its operands and is decoded on the same half-phase.
  always_comb begin
    start   = (active_command == OP_TICK) && (in_op != OP_TICK);
    cmd_e   = start ? in_op : active_command;
    mask_e  = start ? (in_mask & LANE_OK) : latched_mask;
    reg_e   = !start ? latched_register :
              ((in_op == OP_READ_VALUE) ? value_register : in_reg);
    wbyte_e = start ? in_wbyte : latched_write_byte;
    idx_e   = start ? 4'd0 : seg_idx;
    phase_e = start ? 5'd0 : phase;
    for (int i = 0; i < SLOTS; i++) begin
      cap_e[i] = start ? 16'd0 : lane_capture[i];
    end
  end

  // Segment of the command sequence that holds this half-phase.
  assign seg = seg_at(cmd_e, idx_e);

  // Byte shifted out in a transmit segment; the address is read live.
  always_comb begin
    case (seg)
      SEG_TX_AW:  tx_byte = {device_address, 1'b0};
      SEG_TX_AR:  tx_byte = {device_address, 1'b1};
      SEG_TX_REG: tx_byte = reg_e;
      default:    tx_byte = wbyte_e;
    endcase
  end

  // Half-phase decode.
  always_comb begin
    scl    = 1'b1;
    sda    = 1'b1;
    sample = 1'b0;
    last   = 1'b0;
    run    = 1'b0;
    if (cmd_e != OP_TICK) begin
      run = 1'b1;
      case (seg)
        SEG_START: begin
          scl = (phase_e < 5'd2);
          sda = (phase_e == 5'd0);
        end
        SEG_RESTART: begin
          scl = (phase_e == 5'd1) || (phase_e == 5'd2);
          sda = (phase_e < 5'd2);
        end
        SEG_STOP: begin
          scl  = (phase_e != 5'd0);
          sda  = (phase_e == 5'd2);
          last = (phase_e == 5'd2);
        end
        SEG_RX: begin
          scl    = phase_e[0];
          sample = phase_e[0];
        end
        SEG_MACK: begin
          scl = phase_e[0];
          sda = 1'b0;
        end
        SEG_MNACK: begin
          scl = phase_e[0];
        end
        SEG_TX_AW, SEG_TX_REG, SEG_TX_DATA, SEG_TX_AR: begin
          scl = phase_e[0];
          sda = phase_e[4] ? 1'b1 : tx_byte[3'd7 - phase_e[3:1]];
        end
        default: begin
          // Past the end of the sequence: back to an idle bus.
          run = 1'b0;
        end
      endcase
    end
    drive = (!run || sda) ? 4'hF : ~mask_e;
  end

  // Lane capture and result slots.
  always_comb begin
    pins = in_sda & mask_e;
    for (int i = 0; i < SLOTS; i++) begin
      cap_next[i] = sample ? {cap_e[i][14:0], pins[i]} : cap_e[i];
    end
    swapped = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot[i] = '0;
      if (last && (cmd_e == OP_READ_REG)) begin
        slot[i] = {7'd0, cap_e[SLOTS-1-i][7:0]};
      end else if (last && (cmd_e == OP_READ_VALUE)) begin
        swapped = {cap_e[i][7:0], cap_e[i][15:8]};
        slot[i] = swapped[15:1];
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_command     <= OP_TICK;
      seg_idx            <= '0;
      phase              <= '0;
      latched_mask       <= '0;
      latched_register   <= '0;
      latched_write_byte <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        lane_capture[i] <= '0;
      end
    end else if (accept) begin
      if (start) begin
        latched_mask       <= mask_e;
        latched_register   <= reg_e;
        latched_write_byte <= wbyte_e;
      end
      for (int i = 0; i < SLOTS; i++) begin
        lane_capture[i] <= cap_next[i];
      end
      if (!run || last) begin
        active_command <= OP_TICK;
        seg_idx        <= '0;
        phase          <= '0;
      end else begin
        active_command <= cmd_e;
        if (phase_e == seg_len(seg) - 5'd1) begin
          seg_idx <= idx_e + 4'd1;
          phase   <= '0;
        end else begin
          seg_idx <= idx_e;
          phase   <= phase_e + 5'd1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, slot[3], slot[2], slot[1], slot[0], run && !last, drive, scl};
      m_tlast <= last;
    end
  end

endmodule

/* tb/sv/parallel_lane_i2c_master_test.sv */
// Self-checking testbench for the parallel lane I2C master, driven over its streams and APB port.
`timescale 1ns / 1ps

module parallel_lane_i2c_master_test;
  import plim_pkg::*;

  // Result count at which the receiver starts its long hold-off, and its length.
  localparam int unsigned LONG_HOLD_AT     = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  // Random half-phases queued in the random part.
  localparam int unsigned RANDOM_BUDGET    = 240;
  localparam int unsigned RANDOM_PHASES    = 4;

  // How the sampled SDA pins are chosen for a command.
  typedef enum logic [1:0] {
    PINS_RANDOM,
    PINS_HIGH,
    PINS_LOW
  } pin_style_t;

  // One input transfer: the fields of a bus half-phase request.
  typedef struct packed {
    op_t        op;
    logic [3:0] pins;
    logic [7:0] wval;
    logic [7:0] regi;
    logic [3:0] mask;
  } half_phase_req_t;

  // One output transfer: bus levels, status and read slots.
  typedef struct packed {
    logic [3:0][14:0] slots;
    logic             done;
    logic             busy;
    logic [3:0]       sda;
    logic             scl;
  } bus_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  parallel_lane_i2c_master uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Stimulus and result stores.
  half_phase_req_t pending_half_phases [$];
  bus_state_t      awaited_bus_states [$];

  // Predictor state: sequencer, latched command fields, lane shift registers, registers.
  op_t         bus_cmd = OP_TICK;
  logic [7:0]  bus_step = '0;
  logic [3:0]  bus_mask = '0;
  logic [7:0]  bus_reg = '0;
  logic [7:0]  bus_wbyte = '0;
  logic [15:0] lane_shift [4];
  logic [6:0]  cfg_addr = ADDR_RESET;
  logic [7:0]  cfg_valreg = VALREG_RESET;

  // Counters and run control.
  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned received = 0;
  int unsigned mismatches = 0;
  int unsigned n_writes = 0;
  int unsigned n_reg_reads = 0;
  int unsigned n_value_reads = 0;
  int unsigned n_settings = 1;
  int unsigned send_gap = 0;
  int unsigned ready_hold = 0;
  logic        long_hold_done = 1'b0;
  logic        quiet = 1'b0;
  half_phase_req_t drv_item;
  bus_state_t      drv_want;
  bus_state_t      mon_want;
  bus_state_t      mon_got;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Segment at position k of a command's bus sequence.
  function automatic seg_t plan_segment(input op_t cmd, input int k);
    seg_t seg;
    seg = SEG_END;
    case (cmd)
      OP_WRITE_REG: begin
        case (k)
          0: seg = SEG_START;
          1: seg = SEG_TX_AW;
          2: seg = SEG_TX_REG;
          3: seg = SEG_TX_DATA;
          4: seg = SEG_STOP;
          default: seg = SEG_END;
        endcase
      end
      OP_READ_REG: begin
        case (k)
          0: seg = SEG_START;
          1: seg = SEG_TX_AW;
          2: seg = SEG_TX_REG;
          3: seg = SEG_RESTART;
          4: seg = SEG_TX_AR;
          5: seg = SEG_RX;
          6: seg = SEG_MNACK;
          7: seg = SEG_STOP;
          default: seg = SEG_END;
        endcase
      end
      OP_READ_VALUE: begin
        case (k)
          0: seg = SEG_START;
          1: seg = SEG_TX_AW;
          2: seg = SEG_TX_REG;
          3: seg = SEG_RESTART;
          4: seg = SEG_TX_AR;
          5: seg = SEG_RX;
          6: seg = SEG_MACK;
          7: seg = SEG_RX;
          8: seg = SEG_MNACK;
          9: seg = SEG_STOP;
          default: seg = SEG_END;
        endcase
      end
      default: seg = SEG_END;
    endcase
    return seg;
  endfunction

  // Bus half-phases spent in one segment.
  function automatic int unsigned half_phases(input seg_t seg);
    case (seg)
      SEG_START, SEG_STOP:                           return 3;
      SEG_TX_AW, SEG_TX_REG, SEG_TX_DATA, SEG_TX_AR: return 18;
      SEG_RX:                                        return 16;
      SEG_MACK, SEG_MNACK:                           return 2;
      SEG_RESTART:                                   return 4;
      default:                                       return 0;
    endcase
  endfunction

  // Half-phases from the start condition to the end of the stop condition.
  function automatic int unsigned command_length(input op_t cmd);
    int unsigned total;
    total = 0;
    for (int k = 0; k < 10; k++) total += half_phases(plan_segment(cmd, k));
    return total;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 93) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] pick_pins(input pin_style_t style);
    case (style)
      PINS_HIGH: return 4'hF;
      PINS_LOW:  return 4'h0;
      default:   return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // Works out the bus state for one accepted half-phase and advances the sequencer.
  task automatic predict_bus_state(input op_t op, input logic [3:0] mask, input logic [7:0] regi,
                                   input logic [7:0] wval, input logic [3:0] pins,
                                   output bus_state_t r);
    seg_t        seg;
    int unsigned pos;
    int unsigned len;
    logic        found;
    logic        scanning;
    logic        scl;
    logic        sda;
    logic        smp;
    logic        fin;
    logic [7:0]  tx;
    logic [3:0]  masked;
    logic [15:0] v;
    r = '0;
    r.scl = 1'b1;
    r.sda = 4'hF;
    seg = SEG_END;
    found = 1'b0;
    scanning = 1'b1;
    scl = 1'b1;
    sda = 1'b1;
    smp = 1'b0;
    fin = 1'b0;

    // A command is latched only while idle; otherwise the operation is ignored.
    if (bus_cmd == OP_TICK && op != OP_TICK) begin
      bus_cmd = op;
      bus_step = '0;
      bus_mask = mask & LANE_OK;
      bus_reg = (op == OP_READ_VALUE) ? cfg_valreg : regi;
      bus_wbyte = wval;
      for (int i = 0; i < 4; i++) lane_shift[i] = '0;
      case (op)
        OP_WRITE_REG: n_writes++;
        OP_READ_REG:  n_reg_reads++;
        default:      n_value_reads++;
      endcase
    end

    if (bus_cmd != OP_TICK) begin
      // Find the segment holding the current step and the offset within it.
      pos = bus_step;
      for (int k = 0; k < 10; k++) begin
        if (scanning) begin
          seg = plan_segment(bus_cmd, k);
          len = half_phases(seg);
          if (seg == SEG_END) scanning = 1'b0;
          else if (pos >= len) pos -= len;
          else begin
            found = 1'b1;
            scanning = 1'b0;
          end
        end
      end

      if (!found) begin
        bus_cmd = OP_TICK;
        bus_step = '0;
      end else begin
        case (seg)
          SEG_START: begin
            scl = (pos < 2);
            sda = (pos == 0);
          end
          SEG_RESTART: begin
            scl = (pos == 1 || pos == 2);
            sda = (pos < 2);
          end
          SEG_STOP: begin
            scl = (pos != 0);
            sda = (pos == 2);
            fin = (pos == 2);
          end
          SEG_RX: begin
            scl = (pos % 2 == 1);
            sda = 1'b1;
            smp = (pos % 2 == 1);
          end
          SEG_MACK: begin
            scl = (pos % 2 == 1);
            sda = 1'b0;
          end
          SEG_MNACK: begin
            scl = (pos % 2 == 1);
            sda = 1'b1;
          end
          default: begin
            // Byte transmission: the address is taken live, the others are latched.
            case (seg)
              SEG_TX_AW:  tx = {cfg_addr, 1'b0};
              SEG_TX_AR:  tx = {cfg_addr, 1'b1};
              SEG_TX_REG: tx = bus_reg;
              default:    tx = bus_wbyte;
            endcase
            scl = (pos % 2 == 1);
            sda = (pos < 16) ? tx[7 - pos / 2] : 1'b1;
          end
        endcase

        r.scl = scl;
        r.sda = sda ? 4'hF : ~bus_mask;

        // Receive bits are taken on the high half; unmasked lanes read as zero.
        if (smp) begin
          masked = pins & bus_mask;
          for (int i = 0; i < 4; i++) lane_shift[i] = {lane_shift[i][14:0], masked[i]};
        end

        if (fin) begin
          r.done = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (bus_cmd == OP_READ_REG) begin
              r.slots[i] = {7'd0, lane_shift[3 - i][7:0]};
            end else if (bus_cmd == OP_READ_VALUE) begin
              v = {lane_shift[i][7:0], lane_shift[i][15:8]};
              r.slots[i] = v[15:1];
            end
          end
          bus_cmd = OP_TICK;
          bus_step = '0;
        end else begin
          r.busy = 1'b1;
          bus_step = bus_step + 8'd1;
        end
      end
    end
  endtask

  task automatic compare_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on %s at result %0d: expected %h, got %h", what, received, want, got);
    end
  endtask

  // Sender: takes the next pending half-phase after a random gap and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_bus_state(op_t'(s_tuser), s_tdata[3:0], s_tdata[11:4], s_tdata[19:12],
                          s_tdata[23:20], drv_want);
        awaited_bus_states.push_back(drv_want);
        accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_half_phases.size() != 0) begin
          drv_item = pending_half_phases.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= drv_item.op;
          s_tdata <= {drv_item.pins, drv_item.wval, drv_item.regi, drv_item.mask};
          send_gap <= quiet ? 0 : idle_length();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random stalls, one long hold-off so that the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else if (!long_hold_done && received >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      ready_hold <= LONG_HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      ready_hold <= idle_length();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got.scl = m_tdata[0];
      mon_got.sda = m_tdata[4:1];
      mon_got.busy = m_tdata[5];
      mon_got.done = m_tlast;
      for (int i = 0; i < 4; i++) mon_got.slots[i] = m_tdata[6 + 15 * i +: 15];
      if (awaited_bus_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result %0d with nothing awaited: tdata %h", received, m_tdata);
      end else begin
        mon_want = awaited_bus_states.pop_front();
        compare_field("scl_level", 16'(mon_want.scl), 16'(mon_got.scl));
        compare_field("sda_drive", 16'(mon_want.sda), 16'(mon_got.sda));
        compare_field("busy_res", 16'(mon_want.busy), 16'(mon_got.busy));
        compare_field("done_res", 16'(mon_want.done), 16'(mon_got.done));
        for (int i = 0; i < 4; i++)
          compare_field($sformatf("slot%0d_value", i), 16'(mon_want.slots[i]),
                        16'(mon_got.slots[i]));
      end
      received++;
    end
  end

  task automatic queue_item(input op_t op, input logic [3:0] mask, input logic [7:0] regi,
                            input logic [7:0] wval, input logic [3:0] pins);
    half_phase_req_t it;
    it.op = op;
    it.mask = mask;
    it.regi = regi;
    it.wval = wval;
    it.pins = pins;
    pending_half_phases.push_back(it);
    queued++;
  endtask

  // Idle ticks with random content in the other fields.
  task automatic queue_idle(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      queue_item(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  // A command and the ticks that carry it to its stop condition; some of the
  // ticks carry stray commands, which must be ignored while busy.
  task automatic queue_command(input op_t op, input logic [3:0] mask, input logic [7:0] regi,
                               input logic [7:0] wval, input pin_style_t style);
    int unsigned len;
    op_t         stray;
    len = command_length(op);
    queue_item(op, mask, regi, wval, pick_pins(style));
    for (int unsigned i = 1; i < len; i++) begin
      stray = ($urandom_range(0, 7) == 0) ? op_t'($urandom_range(1, 3)) : OP_TICK;
      queue_item(stray, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), pick_pins(style));
    end
  endtask

  // Waits until every transfer is out and the sequencer is back at idle.
  task automatic wait_until_idle();
    while (pending_half_phases.size() != 0 || s_tvalid || awaited_bus_states.size() != 0 ||
           bus_cmd != OP_TICK)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB register write: setup cycle, then access cycle.
  task automatic write_register(input logic index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_DEVICE_ADDRESS) cfg_addr = value[6:0];
    else cfg_valreg = value[7:0];
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [6:0] addr, input logic [7:0] valreg);
    write_register(REG_DEVICE_ADDRESS, {25'd0, addr});
    write_register(REG_VALUE_REGISTER, {24'd0, valreg});
    n_settings++;
  endtask

  // Main sequence: directed commands at reset settings, then random phases.
  initial begin
    int unsigned phase_start;
    op_t         cmd;
    pin_style_t  style;
    for (int i = 0; i < 4; i++) lane_shift[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle bus, extremes of each field, every command.
    queue_idle(2);
    queue_command(OP_WRITE_REG, 4'hF, 8'hFF, 8'h00, PINS_RANDOM);
    queue_command(OP_READ_REG, 4'h9, 8'h00, 8'hFF, PINS_RANDOM);
    // Value read with every pin high: masked lanes give all-ones bytes, a result
    // of minus one, while the unmasked lanes must still read as zero.
    queue_command(OP_READ_VALUE, 4'h5, 8'hA5, 8'h00, PINS_HIGH);
    queue_idle(2);
    wait_until_idle();

    // Random phases, the first two at the register extremes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       apply_setting(7'd0, 8'd0);
        1:       apply_setting(7'd127, 8'd255);
        default: apply_setting(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
      endcase
      quiet = (p == 2);
      phase_start = queued;
      while (queued - phase_start < RANDOM_BUDGET / RANDOM_PHASES) begin
        queue_idle($urandom_range(0, 3));
        cmd = op_t'($urandom_range(1, 3));
        case ($urandom_range(0, 9))
          0:       style = PINS_HIGH;
          1:       style = PINS_LOW;
          default: style = PINS_RANDOM;
        endcase
        queue_command(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), style);
      end
      wait_until_idle();
    end
    quiet = 1'b0;

    repeat (8) @(negedge clk);
    $display("Covered %0d half-phases: %0d writes, %0d register reads, %0d value reads.",
             accepted, n_writes, n_reg_reads, n_value_reads);
    $display("Checked %0d results under %0d register settings, one long receiver stall.",
             received, n_settings);
    if (mismatches == 0 && awaited_bus_states.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results still awaited.", awaited_bus_states.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
